FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file bdg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, disabled while rst is high.
`define BDG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, same clocking and disable.
`define BDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bdg_pkg.sv
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared types, codes and reset values for the button debounce gesture unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdg_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 16;
  localparam int NOW_W         = 32;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // Operation codes
  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_RESYNC   = 2'd1;
  localparam logic [1:0] OP_SUPPRESS = 2'd2;

  // Configuration register indexes
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  // Event kinds
  localparam logic EV_SHORT = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic             pressed;
    logic [NOW_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic hit;
    logic kind;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/bdg_in_reg.sv
// ----------------------------------------------------------------------------
// bdg_in_reg
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdg_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bdg_pkg::item_t in_item,
  input  wire logic          out_free,
  output logic               fire,
  output bdg_pkg::item_t     item
);
  import bdg_pkg::*;

  logic vld;

  assign fire     = vld && out_free;
  assign in_stall = vld && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!in_stall) begin
      vld <= in_valid;
    end
  end

  // Payload loads whenever the stage is free to take a new item.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bdg_core.sv
// ----------------------------------------------------------------------------
// bdg_core
// Debounce and gesture state with its combinational next-state update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdg_core #(
  parameter int TIME_BITS = bdg_pkg::TIME_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     fire,
  input  wire bdg_pkg::item_t           item,
  input  wire logic                     cfg_write,
  input  wire logic                     cfg_index,
  input  wire logic [bdg_pkg::CFG_W-1:0] cfg_data,
  output bdg_pkg::res_t                 res
);
  import bdg_pkg::*;

  logic [CFG_W-1:0]     debounce_time;
  logic [CFG_W-1:0]     long_press_time;
  logic                 raw_level,        raw_level_next;
  logic                 stable_level,     stable_level_next;
  logic                 armed_flag,       armed_flag_next;
  logic                 long_reported,    long_reported_next;
  logic [TIME_BITS-1:0] raw_change_time,  raw_change_time_next;
  logic [TIME_BITS-1:0] press_start_time, press_start_time_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] deb_t;
  logic [TIME_BITS-1:0] lp_t;

  assign now_t = TIME_BITS'(item.now_time);
  assign deb_t = TIME_BITS'(debounce_time);
  assign lp_t  = TIME_BITS'(long_press_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_time   <= cfg_data;
        REG_LONG_PRESS: long_press_time <= cfg_data;
      endcase
    end
  end

  always_comb begin
    logic                 deb_ok;
    logic                 short_out;
    logic [TIME_BITS-1:0] el_raw;
    logic [TIME_BITS-1:0] el_press;
    raw_level_next        = raw_level;
    stable_level_next     = stable_level;
    armed_flag_next       = armed_flag;
    long_reported_next    = long_reported;
    raw_change_time_next  = raw_change_time;
    press_start_time_next = press_start_time;
    res                   = '0;
    deb_ok                = 1'b0;
    short_out             = 1'b0;
    el_raw                = '0;
    el_press              = '0;

    unique case (item.op)
      OP_SAMPLE: begin
        raw_level_next = item.pressed;
        if (item.pressed != raw_level) begin
          raw_change_time_next = now_t;
        end
        el_raw = now_t - raw_change_time_next;
        deb_ok = (el_raw >= deb_t);

        if (raw_level_next != stable_level && deb_ok) begin
          stable_level_next = raw_level_next;
          if (raw_level_next) begin
            press_start_time_next = now_t;
            long_reported_next    = 1'b0;
          end else if (!armed_flag) begin
            armed_flag_next = 1'b1;
          end else if (!long_reported) begin
            short_out = 1'b1;
          end
        end

        if (short_out) begin
          res.hit  = 1'b1;
          res.kind = EV_SHORT;
        end else begin
          if (!armed_flag_next && !stable_level_next && deb_ok) begin
            armed_flag_next = 1'b1;
          end
          // Long press once the stable press has held long enough.
          el_press = now_t - press_start_time_next;
          if (armed_flag_next && stable_level_next && !long_reported_next &&
              long_press_time != '0 && el_press >= lp_t) begin
            long_reported_next = 1'b1;
            res.hit            = 1'b1;
            res.kind           = EV_LONG;
          end
        end
      end
      OP_RESYNC: begin
        raw_level_next        = item.pressed;
        stable_level_next     = item.pressed;
        armed_flag_next       = 1'b0;
        long_reported_next    = 1'b0;
        raw_change_time_next  = now_t;
        press_start_time_next = item.pressed ? now_t : '0;
      end
      OP_SUPPRESS: begin
        if (stable_level) begin
          long_reported_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!fire) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level        <= 1'b0;
      stable_level     <= 1'b0;
      armed_flag       <= 1'b0;
      long_reported    <= 1'b0;
      raw_change_time  <= '0;
      press_start_time <= '0;
    end else if (fire) begin
      raw_level        <= raw_level_next;
      stable_level     <= stable_level_next;
      armed_flag       <= armed_flag_next;
      long_reported    <= long_reported_next;
      raw_change_time  <= raw_change_time_next;
      press_start_time <= press_start_time_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bdg_out_reg.sv
// ----------------------------------------------------------------------------
// bdg_out_reg
// Result register: holds a gesture item until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdg_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bdg_pkg::res_t res,
  output logic               out_free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               event_kind
);
  import bdg_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.hit) begin
      event_kind <= res.kind;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/button_debounce_gesture_unit.sv
// One sample item per clock, back to back, unless a held result is stalled.
// An item is registered at its input. In the next cycle, unless the result
// register is held by a stall, the debounce and gesture state is updated from
// it, and any short or long press is loaded into the result register at that
// same edge. The state update is combinational; its path holds two timestamp
// subtractions with their compares.
// The input stalls only while a held result is itself stalled.
// ----------------------------------------------------------------------------
// button_debounce_gesture_unit
// Button debouncer with short and long press detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_gesture_unit #(
  parameter int TIME_BITS = bdg_pkg::TIME_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                op,
  input  wire logic                      pressed,
  input  wire logic [bdg_pkg::NOW_W-1:0] now_time,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           event_kind,
  input  wire logic                      cfg_write,
  input  wire logic                      cfg_index,
  input  wire logic [bdg_pkg::CFG_W-1:0] cfg_data
);
  import bdg_pkg::*;

  item_t in_item;
  item_t item;
  res_t  res;
  logic  fire;
  logic  out_free;

  assign in_item.op       = op;
  assign in_item.pressed  = pressed;
  assign in_item.now_time = now_time;

  bdg_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .fire     (fire),
    .item     (item)
  );

  bdg_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  bdg_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind)
  );

endmodule

`default_nettype wire

FILE: rtl/bdg_checker.sv
// ----------------------------------------------------------------------------
// bdg_checker
// Port-level checks for the button debounce gesture unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bdg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic event_kind
);

  // A held result stays put while stalled.
  `BDG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `BDG_ASSERT_NEXT(a_kind_hold, out_valid && out_stall, $stable(event_kind), "kind changed")

  // Reset leaves no result pending.
  `BDG_ASSERT_IMPL(a_rst_empty, $past(rst), !out_valid, "result present after reset")

  // Every new result comes from an item accepted earlier, through the input and result registers.
  `BDG_ASSERT_IMPL(a_out_src, $rose(out_valid), $past(in_valid && !in_stall, 2), "stray result")

endmodule

bind button_debounce_gesture_unit bdg_checker u_bdg_checker (.*);

`default_nettype wire
